>>> rtl/maze_depth_first_solver_unit_assert.svh
// Assertion macros used by the solver RTL.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef MAZE_DEPTH_FIRST_SOLVER_UNIT_ASSERT_SVH
`define MAZE_DEPTH_FIRST_SOLVER_UNIT_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define MDFS_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define MDFS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define MDFS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/mdfs_pkg.sv
`default_nettype none

package mdfs_pkg;

  // Configuration port geometry and register indexes.
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 5;
  localparam logic [CfgAddrW-1:0] CFG_MAZE_SIZE = 3'd0;
  localparam logic [CfgAddrW-1:0] CFG_START_ROW = 3'd1;
  localparam logic [CfgAddrW-1:0] CFG_START_COL = 3'd2;
  localparam logic [CfgAddrW-1:0] CFG_GOAL_ROW  = 3'd3;
  localparam logic [CfgAddrW-1:0] CFG_GOAL_COL  = 3'd4;

  localparam logic [4:0] MazeSizeReset = 5'd11;

  // Commands.
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_SOLVE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Cell marks.
  localparam logic [1:0] MARK_OPEN = 2'd0;
  localparam logic [1:0] MARK_WALL = 2'd1;
  localparam logic [1:0] MARK_PATH = 2'd2;
  localparam logic [1:0] MARK_DEAD = 2'd3;

  // Facing and move directions.
  localparam logic [1:0] FACE_UP    = 2'd0;
  localparam logic [1:0] FACE_RIGHT = 2'd1;
  localparam logic [1:0] FACE_DOWN  = 2'd2;
  localparam logic [1:0] FACE_LEFT  = 2'd3;

  // Solve status codes.
  localparam logic [1:0] STAT_DONE    = 2'd0;
  localparam logic [1:0] STAT_FOUND   = 2'd1;
  localparam logic [1:0] STAT_NO_PATH = 2'd2;
  localparam logic [1:0] STAT_OUTSIDE = 2'd3;

  // Three neighbors are tried per cell; this is the index of the last one.
  localparam logic [1:0] LastTry = 2'd2;

  localparam int VisitW = 9;
  localparam logic [VisitW-1:0] VisitMax = 9'h1FF;

  typedef struct packed {
    logic [1:0] command;
    logic [3:0] row;
    logic [3:0] col;
    logic       is_wall;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [1:0]        cell_mark;
    logic [VisitW-1:0] visit_count;
  } out_t;

  typedef struct packed {
    logic [4:0] maze_size;
    logic [3:0] start_row;
    logic [3:0] start_col;
    logic [3:0] goal_row;
    logic [3:0] goal_col;
  } cfg_t;

  // Direction of the k-th neighbor tried for a given facing.
  function automatic logic [1:0] try_dir(input logic [1:0] face, input logic [1:0] k);
    logic [1:0] d;
    case (face)
      FACE_UP:    d = (k == 2'd0) ? FACE_RIGHT : (k == 2'd1) ? FACE_UP : FACE_LEFT;
      FACE_RIGHT: d = (k == 2'd0) ? FACE_DOWN : (k == 2'd1) ? FACE_RIGHT : FACE_UP;
      FACE_DOWN:  d = (k == 2'd0) ? FACE_DOWN : (k == 2'd1) ? FACE_RIGHT : FACE_LEFT;
      default:    d = (k == 2'd0) ? FACE_DOWN : (k == 2'd1) ? FACE_UP : FACE_LEFT;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

>>> rtl/mdfs_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port, registered read data.
module mdfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/mdfs_walk.sv
`default_nettype none
`include "maze_depth_first_solver_unit_assert.svh"

// Command sequencer and depth-first walker around the cell store and path stack.
module mdfs_walk #(
  parameter int GRID_SIZE = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire mdfs_pkg::cfg_t cfg,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire mdfs_pkg::in_t in_data,
  input  wire logic          slot_free,
  output logic               res_valid,
  output mdfs_pkg::out_t     res_data
);
  import mdfs_pkg::*;

  localparam int RW       = $clog2(GRID_SIZE);
  localparam int CW       = 2 * RW;
  localparam int DW       = CW + 1;
  localparam int SEW      = CW + 2;
  localparam int NW       = $clog2(GRID_SIZE + 1);
  localparam int Cells    = GRID_SIZE * GRID_SIZE;
  localparam int MemDepth = 2 ** CW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_VISIT,
    ST_TRY,
    ST_CHECK,
    ST_DEAD,
    ST_POP
  } state_t;

  state_t            state_r, state_nxt;
  logic [RW-1:0]     top_row_r, top_row_nxt;
  logic [RW-1:0]     top_col_r, top_col_nxt;
  logic [1:0]        face_r, face_nxt;
  logic [1:0]        k_r, k_nxt;
  logic [RW-1:0]     nrow_r, nrow_nxt;
  logic [RW-1:0]     ncol_r, ncol_nxt;
  logic [1:0]        ndir_r, ndir_nxt;
  logic [DW-1:0]     depth_r, depth_nxt;
  logic [VisitW-1:0] visits_r, visits_nxt;
  logic              rd_inside_r, rd_inside_nxt;

  logic [NW-1:0] eff_n;
  logic          start_ok;
  logic          in_grid;
  logic          in_accept;
  logic          at_goal;
  logic [1:0]    cand_dir;
  logic          cand_ok;
  logic [RW-1:0] cand_row;
  logic [RW-1:0] cand_col;
  logic          walk_busy;
  logic          solve_go;

  logic          cell_we;
  logic [CW-1:0] cell_waddr;
  logic [1:0]    cell_wdata;
  logic [CW-1:0] cell_raddr;
  logic [1:0]    cell_rdata;

  logic           stk_we;
  logic [CW-1:0]  stk_waddr;
  logic [SEW-1:0] stk_wdata;
  logic [CW-1:0]  stk_raddr;
  logic [SEW-1:0] stk_rdata;

  // Maze size in use, clipped to the grid.
  always_comb begin
    if (32'(cfg.maze_size) > 32'(GRID_SIZE)) begin
      eff_n = NW'(GRID_SIZE);
    end else begin
      eff_n = NW'(cfg.maze_size);
    end
  end

  assign start_ok = (32'(cfg.start_row) < 32'(eff_n)) && (32'(cfg.start_col) < 32'(eff_n)) &&
                    (32'(cfg.goal_row) < 32'(eff_n)) && (32'(cfg.goal_col) < 32'(eff_n));
  assign in_grid  = (32'(in_data.row) < 32'(GRID_SIZE)) && (32'(in_data.col) < 32'(GRID_SIZE));
  assign at_goal  = (32'(top_row_r) == 32'(cfg.goal_row)) &&
                    (32'(top_col_r) == 32'(cfg.goal_col));

  // A new item is taken only when the walker is idle and the output slot is free.
  assign in_stall  = (state_r != ST_IDLE) || !slot_free;
  assign in_accept = in_valid && !in_stall;

  // Candidate neighbor of the stack top for the current try.
  always_comb begin
    cand_dir = try_dir(face_r, k_r);
    cand_row = top_row_r;
    cand_col = top_col_r;
    case (cand_dir)
      FACE_UP: begin
        cand_ok  = (top_row_r != '0);
        cand_row = top_row_r - RW'(1);
      end
      FACE_RIGHT: begin
        cand_ok  = (32'(top_col_r) + 32'd1) < 32'(eff_n);
        cand_col = top_col_r + RW'(1);
      end
      FACE_DOWN: begin
        cand_ok  = (32'(top_row_r) + 32'd1) < 32'(eff_n);
        cand_row = top_row_r + RW'(1);
      end
      default: begin
        cand_ok  = (top_col_r != '0);
        cand_col = top_col_r - RW'(1);
      end
    endcase
  end

  // Next-state logic and memory port control.
  always_comb begin
    state_nxt     = state_r;
    top_row_nxt   = top_row_r;
    top_col_nxt   = top_col_r;
    face_nxt      = face_r;
    k_nxt         = k_r;
    nrow_nxt      = nrow_r;
    ncol_nxt      = ncol_r;
    ndir_nxt      = ndir_r;
    depth_nxt     = depth_r;
    visits_nxt    = visits_r;
    rd_inside_nxt = rd_inside_r;

    cell_we    = 1'b0;
    cell_waddr = '0;
    cell_wdata = MARK_OPEN;
    cell_raddr = '0;
    stk_we     = 1'b0;
    stk_waddr  = '0;
    stk_wdata  = '0;
    stk_raddr  = '0;

    res_valid             = 1'b0;
    res_data.status       = STAT_DONE;
    res_data.cell_mark    = MARK_OPEN;
    res_data.visit_count  = visits_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          case (in_data.command)
            CMD_LOAD: begin
              res_valid = 1'b1;
              if (in_grid) begin
                cell_we    = 1'b1;
                cell_waddr = {RW'(in_data.row), RW'(in_data.col)};
                cell_wdata = in_data.is_wall ? MARK_WALL : MARK_OPEN;
              end
            end
            CMD_SOLVE: begin
              if (!start_ok) begin
                res_valid            = 1'b1;
                res_data.status      = STAT_OUTSIDE;
                res_data.visit_count = '0;
                visits_nxt           = '0;
                depth_nxt            = '0;
              end else begin
                // Enter the start cell and push it facing right.
                cell_we     = 1'b1;
                cell_waddr  = {RW'(cfg.start_row), RW'(cfg.start_col)};
                cell_wdata  = MARK_PATH;
                stk_we      = 1'b1;
                stk_waddr   = '0;
                stk_wdata   = {RW'(cfg.start_row), RW'(cfg.start_col), FACE_RIGHT};
                visits_nxt  = VisitW'(1);
                depth_nxt   = DW'(1);
                top_row_nxt = RW'(cfg.start_row);
                top_col_nxt = RW'(cfg.start_col);
                face_nxt    = FACE_RIGHT;
                state_nxt   = ST_VISIT;
              end
            end
            CMD_READ: begin
              cell_raddr    = {RW'(in_data.row), RW'(in_data.col)};
              rd_inside_nxt = in_grid;
              state_nxt     = ST_RD_WAIT;
            end
            default: begin
              res_valid = 1'b1;
            end
          endcase
        end
      end

      ST_RD_WAIT: begin
        res_valid          = 1'b1;
        res_data.cell_mark = rd_inside_r ? cell_rdata : MARK_WALL;
        state_nxt          = ST_IDLE;
      end

      ST_VISIT: begin
        if (at_goal) begin
          res_valid       = 1'b1;
          res_data.status = STAT_FOUND;
          state_nxt       = ST_IDLE;
        end else begin
          k_nxt     = '0;
          state_nxt = ST_TRY;
        end
      end

      ST_TRY: begin
        if (cand_ok) begin
          cell_raddr = {cand_row, cand_col};
          nrow_nxt   = cand_row;
          ncol_nxt   = cand_col;
          ndir_nxt   = cand_dir;
          state_nxt  = ST_CHECK;
        end else if (k_r == LastTry) begin
          state_nxt = ST_DEAD;
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end

      ST_CHECK: begin
        if (cell_rdata == MARK_OPEN) begin
          // Enter the neighbor and push it.
          cell_we     = 1'b1;
          cell_waddr  = {nrow_r, ncol_r};
          cell_wdata  = MARK_PATH;
          stk_we      = 1'b1;
          stk_waddr   = depth_r[CW-1:0];
          stk_wdata   = {nrow_r, ncol_r, ndir_r};
          depth_nxt   = depth_r + DW'(1);
          visits_nxt  = (visits_r == VisitMax) ? visits_r : visits_r + VisitW'(1);
          top_row_nxt = nrow_r;
          top_col_nxt = ncol_r;
          face_nxt    = ndir_r;
          state_nxt   = ST_VISIT;
        end else if (k_r == LastTry) begin
          state_nxt = ST_DEAD;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = ST_TRY;
        end
      end

      ST_DEAD: begin
        // Mark the dead end and back out to the entry below it.
        cell_we    = 1'b1;
        cell_waddr = {top_row_r, top_col_r};
        cell_wdata = MARK_DEAD;
        depth_nxt  = depth_r - DW'(1);
        if (depth_r == DW'(1)) begin
          res_valid       = 1'b1;
          res_data.status = STAT_NO_PATH;
          state_nxt       = ST_IDLE;
        end else begin
          stk_raddr = CW'(depth_r - DW'(2));
          state_nxt = ST_POP;
        end
      end

      ST_POP: begin
        top_row_nxt = stk_rdata[SEW-1 -: RW];
        top_col_nxt = stk_rdata[RW+1 -: RW];
        face_nxt    = stk_rdata[1:0];
        state_nxt   = ST_VISIT;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and walker registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      depth_r  <= '0;
      visits_r <= '0;
    end else begin
      state_r  <= state_nxt;
      depth_r  <= depth_nxt;
      visits_r <= visits_nxt;
    end
    top_row_r   <= top_row_nxt;
    top_col_r   <= top_col_nxt;
    face_r      <= face_nxt;
    k_r         <= k_nxt;
    nrow_r      <= nrow_nxt;
    ncol_r      <= ncol_nxt;
    ndir_r      <= ndir_nxt;
    rd_inside_r <= rd_inside_nxt;
  end

  // Cell marks, one per grid position.
  mdfs_ram #(
    .WIDTH (2),
    .DEPTH (MemDepth)
  ) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  // Path stack of cell position and facing.
  mdfs_ram #(
    .WIDTH (SEW),
    .DEPTH (MemDepth)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // The walk is running in any state but idle and the read wait.
  assign walk_busy = (state_r != ST_IDLE) && (state_r != ST_RD_WAIT);
  assign solve_go  = in_accept && (in_data.command == CMD_SOLVE) && start_ok;

  `MDFS_ASSERT(a_depth_bound, 32'(depth_r) <= Cells, "path stack deeper than the grid")
  `MDFS_ASSERT_IMP(a_walk_nonempty, walk_busy, depth_r != '0, "walk active with an empty stack")
  `MDFS_ASSERT_IMP(a_res_slot, res_valid, slot_free, "result produced while output slot is full")
  `MDFS_ASSERT_NXT(a_solve_start, solve_go, state_r == ST_VISIT && depth_r == DW'(1), "bad solve start")

endmodule

`default_nettype wire

>>> rtl/maze_depth_first_solver_unit.sv
// Depth-first maze solver. Cells are loaded one per transfer and marked wall or open; a solve
// walks from the start cell depth-first, marking cells on-path or dead-end, and reports goal
// found, no path, or start/goal outside the maze along with the visit count. A load, and a
// solve whose start or goal lies outside the maze, is answered in the cycle it is accepted; a
// read waits on the registered read of the cell store. Otherwise a solve, for every cell
// entered, checks for the goal and then probes neighbors in turn, an in-bounds one through a
// try and a check state and an out-of-bounds direction through a try state alone; a back-out
// from a dead end to the cell below it passes through the dead, pop and visit states, and a
// dead start cell through the dead state. Every neighbor probe passes one at a time through
// the single read port of the cell store. The next command is taken once the previous
// result is in the output register and that register is free or being drained. Stores need
// no clearing after reset; reading a cell that was never loaded returns an undefined mark.
`default_nettype none

module maze_depth_first_solver_unit #(
  parameter int GRID_SIZE = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [mdfs_pkg::CfgAddrW-1:0]   cfg_addr,
  input  wire logic [mdfs_pkg::CfgDataW-1:0]   cfg_wdata,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire mdfs_pkg::in_t                   in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output mdfs_pkg::out_t                       out_data
);
  import mdfs_pkg::*;

  cfg_t cfg_r;
  logic out_valid_r;
  out_t out_data_r;
  logic slot_free;
  logic res_valid;
  out_t res_data;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.maze_size <= MazeSizeReset;
      cfg_r.start_row <= '0;
      cfg_r.start_col <= '0;
      cfg_r.goal_row  <= '0;
      cfg_r.goal_col  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_MAZE_SIZE: cfg_r.maze_size <= cfg_wdata;
        CFG_START_ROW: cfg_r.start_row <= cfg_wdata[3:0];
        CFG_START_COL: cfg_r.start_col <= cfg_wdata[3:0];
        CFG_GOAL_ROW:  cfg_r.goal_row  <= cfg_wdata[3:0];
        CFG_GOAL_COL:  cfg_r.goal_col  <= cfg_wdata[3:0];
        default: begin
        end
      endcase
    end
  end

  // Output register: filled by a finished result, emptied by a transfer.
  assign slot_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  mdfs_walk #(
    .GRID_SIZE (GRID_SIZE)
  ) u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .slot_free (slot_free),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

endmodule

`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 100ps

import mdfs_pkg::*;

localparam int GRID = 16;
localparam int CELL_COUNT = GRID * GRID;

// The fourth command code does nothing and reports status done.
localparam logic [1:0] CMD_UNUSED = 2'd3;

// Tracks the cell marks, the settings and the visit count of the solver and
// queues the reply that each accepted command must produce.
class maze_checker;
  logic [1:0]        marks [CELL_COUNT];
  logic [4:0]        maze_size;
  logic [3:0]        start_row;
  logic [3:0]        start_col;
  logic [3:0]        goal_row;
  logic [3:0]        goal_col;
  logic [VisitW-1:0] visits;
  logic [1:0]        probe_order [4][3];
  out_t              awaited_replies [$];
  int                errors;
  int                solves;
  int                found;
  int                no_path;
  int                outside;
  int                reads;

  function new();
    foreach (marks[i]) marks[i] = MARK_OPEN;
    maze_size = MazeSizeReset;
    start_row = '0;
    start_col = '0;
    goal_row  = '0;
    goal_col  = '0;
    visits    = '0;
    errors    = 0;
    solves    = 0;
    found     = 0;
    no_path   = 0;
    outside   = 0;
    reads     = 0;
    // Neighbors tried from a cell, by the direction the walk is facing.
    probe_order[FACE_UP]    = '{FACE_RIGHT, FACE_UP, FACE_LEFT};
    probe_order[FACE_RIGHT] = '{FACE_DOWN, FACE_RIGHT, FACE_UP};
    probe_order[FACE_DOWN]  = '{FACE_DOWN, FACE_RIGHT, FACE_LEFT};
    probe_order[FACE_LEFT]  = '{FACE_DOWN, FACE_UP, FACE_LEFT};
  endfunction

  function void write_reg(logic [CfgAddrW-1:0] addr, logic [CfgDataW-1:0] value);
    case (addr)
      CFG_MAZE_SIZE: maze_size = value;
      CFG_START_ROW: start_row = value[3:0];
      CFG_START_COL: start_col = value[3:0];
      CFG_GOAL_ROW:  goal_row  = value[3:0];
      CFG_GOAL_COL:  goal_col  = value[3:0];
      default: ;
    endcase
  endfunction

  // Depth-first walk from the start cell; returns the solve status.
  function logic [1:0] walk_maze();
    int         n;
    int         goal;
    int         depth;
    int         cur;
    int         r;
    int         c;
    int         nr;
    int         nc;
    int         ncell;
    int         k;
    int         stack_cell [CELL_COUNT];
    logic [1:0] stack_face [CELL_COUNT];
    logic [1:0] face;
    logic [1:0] dir;
    bit         moved;
    n = (maze_size > 5'd16) ? GRID : int'(maze_size);
    visits = '0;
    if (int'(start_row) >= n || int'(start_col) >= n ||
        int'(goal_row) >= n || int'(goal_col) >= n) begin
      return STAT_OUTSIDE;
    end
    goal = int'({goal_row, goal_col});
    cur = int'({start_row, start_col});
    // The start cell is entered even when it holds a wall.
    marks[cur] = MARK_PATH;
    visits = visits + 9'd1;
    stack_cell[0] = cur;
    stack_face[0] = FACE_RIGHT;
    depth = 1;
    while (depth > 0) begin
      cur = stack_cell[depth-1];
      face = stack_face[depth-1];
      if (cur == goal) begin
        return STAT_FOUND;
      end
      r = cur / GRID;
      c = cur % GRID;
      moved = 1'b0;
      for (k = 0; k < 3 && !moved; k++) begin
        dir = probe_order[face][k];
        nr = r;
        nc = c;
        case (dir)
          FACE_UP:    nr = r - 1;
          FACE_RIGHT: nc = c + 1;
          FACE_DOWN:  nr = r + 1;
          default:    nc = c - 1;
        endcase
        if (nr >= 0 && nc >= 0 && nr < n && nc < n && depth < CELL_COUNT) begin
          ncell = nr * GRID + nc;
          // Cells already on the path or dead are never entered again.
          if (marks[ncell] == MARK_OPEN) begin
            marks[ncell] = MARK_PATH;
            if (visits != VisitMax) visits = visits + 9'd1;
            stack_cell[depth] = ncell;
            stack_face[depth] = dir;
            depth++;
            moved = 1'b1;
          end
        end
      end
      // Nowhere left to go: mark the cell dead and back up.
      if (!moved) begin
        marks[cur] = MARK_DEAD;
        depth--;
      end
    end
    return STAT_NO_PATH;
  endfunction

  function void note_command(in_t item);
    out_t want;
    want = '0;
    case (item.command)
      CMD_LOAD: marks[{item.row, item.col}] = item.is_wall ? MARK_WALL : MARK_OPEN;
      CMD_SOLVE: begin
        want.status = walk_maze();
        solves++;
        if (want.status == STAT_FOUND) found++;
        else if (want.status == STAT_NO_PATH) no_path++;
        else outside++;
      end
      CMD_READ: begin
        want.cell_mark = marks[{item.row, item.col}];
        reads++;
      end
      default: ;
    endcase
    want.visit_count = visits;
    awaited_replies.insert(awaited_replies.size(), want);
  endfunction

  function void check_reply(out_t got);
    out_t want;
    if (awaited_replies.size() == 0) begin
      $error("reply with no command waiting: status %0d, cell_mark %0d, visit_count %0d",
             got.status, got.cell_mark, got.visit_count);
      errors++;
      return;
    end
    want = awaited_replies.pop_front();
    if (got.status !== want.status) begin
      $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
      errors++;
    end
    if (got.cell_mark !== want.cell_mark) begin
      $error("cell_mark mismatch: expected %0d, actual %0d", want.cell_mark, got.cell_mark);
      errors++;
    end
    if (got.visit_count !== want.visit_count) begin
      $error("visit_count mismatch: expected %0d, actual %0d",
             want.visit_count, got.visit_count);
      errors++;
    end
  endfunction
endclass

module testbench;
  typedef enum int {
    PACE_SLOW_DRAIN,
    PACE_SLOW_FEED,
    PACE_FULL
  } pace_e;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr  = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  in_t                 in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_t                out_data;

  maze_checker maze_watch;
  pace_e       pace = PACE_SLOW_DRAIN;
  int          sent = 0;
  int          hold_requests = 0;

  maze_depth_first_solver_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // A hang anywhere ends the run here.
  initial begin
    #20_000_000;
    $display("testbench failed");
    $finish;
  end

  function automatic in_t make_item(logic [1:0] command, logic [3:0] row, logic [3:0] col,
                                    logic is_wall);
    in_t item;
    item.command = command;
    item.row     = row;
    item.col     = col;
    item.is_wall = is_wall;
    return item;
  endfunction

  // Offer one command and hold it until the transfer happens.
  task automatic send_item(in_t item);
    int idle_pct;
    idle_pct = (pace == PACE_SLOW_DRAIN) ? 36 : (pace == PACE_SLOW_FEED) ? 59 : 0;
    while (int'($urandom_range(99)) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    maze_watch.note_command(item);
    sent++;
  endtask

  // Let the solver drain, then write all five registers.
  task automatic configure(logic [4:0] size, logic [3:0] sr, logic [3:0] sc,
                           logic [3:0] gr, logic [3:0] gc);
    logic [CfgAddrW-1:0] addrs [5];
    logic [CfgDataW-1:0] vals [5];
    int                  i;
    addrs = '{CFG_MAZE_SIZE, CFG_START_ROW, CFG_START_COL, CFG_GOAL_ROW, CFG_GOAL_COL};
    vals  = '{size, {1'b0, sr}, {1'b0, sc}, {1'b0, gr}, {1'b0, gc}};
    in_valid <= 1'b0;
    while (maze_watch.awaited_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    for (i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= addrs[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
      maze_watch.write_reg(addrs[i], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // Result side: check each transfer out, stall at the current pace, and
  // serve requests for a long hold-off.
  initial begin : result_side
    int hold_left;
    int holds_served;
    hold_left    = 0;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) maze_watch.check_reply(out_data);
      if (holds_served < hold_requests) begin
        holds_served++;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (pace == PACE_SLOW_DRAIN) begin
        out_stall <= (int'($urandom_range(99)) < 59);
      end else if (pace == PACE_SLOW_FEED) begin
        out_stall <= (int'($urandom_range(99)) < 36);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : command_side
    int  r;
    int  c;
    int  n;
    int  eff;
    int  sr;
    int  sc;
    int  gr;
    int  gc;
    int  kind;
    int  pick;
    int  base;
    int  span;
    int  done;
    int  reps;
    bit  squeeze;
    bit  wall;
    maze_watch = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Load the whole grid so that every read and every probe of a solve
    // lands on a cell that holds a defined mark.
    for (r = 0; r < GRID; r++) begin
      for (c = 0; c < GRID; c++) begin
        send_item(make_item(CMD_LOAD, 4'(r), 4'(c), int'($urandom_range(99)) < 30));
      end
    end

    // Reset settings put start and goal on the same cell: found at once.
    send_item(make_item(CMD_SOLVE, 4'd0, 4'd0, 1'b0));
    send_item(make_item(CMD_READ, 4'd0, 4'd0, 1'b0));
    send_item(make_item(CMD_READ, 4'd15, 4'd15, 1'b1));
    send_item(make_item(CMD_UNUSED, 4'd15, 4'd15, 1'b1));
    // A maze of size zero holds no cell at all.
    configure(5'd0, 4'd0, 4'd0, 4'd0, 4'd0);
    send_item(make_item(CMD_SOLVE, 4'd0, 4'd0, 1'b0));
    configure(5'd1, 4'd0, 4'd0, 4'd0, 4'd0);
    send_item(make_item(CMD_SOLVE, 4'd0, 4'd0, 1'b0));
    // The start cell is a wall and is entered anyway.
    configure(5'd4, 4'd1, 4'd1, 4'd3, 4'd3);
    send_item(make_item(CMD_LOAD, 4'd1, 4'd1, 1'b1));
    send_item(make_item(CMD_SOLVE, 4'd0, 4'd0, 1'b0));
    send_item(make_item(CMD_READ, 4'd1, 4'd1, 1'b0));
    // Goal and then start just past the edge of the maze.
    configure(5'd4, 4'd0, 4'd0, 4'd0, 4'd4);
    send_item(make_item(CMD_SOLVE, 4'd0, 4'd0, 1'b0));
    configure(5'd4, 4'd4, 4'd0, 4'd0, 4'd0);
    send_item(make_item(CMD_SOLVE, 4'd0, 4'd0, 1'b0));
    // Oversized maze with a walled goal in the far corner, solved twice so
    // that the second walk meets the marks left by the first.
    configure(5'd31, 4'd0, 4'd0, 4'd15, 4'd15);
    send_item(make_item(CMD_LOAD, 4'd15, 4'd15, 1'b1));
    send_item(make_item(CMD_LOAD, 4'd0, 4'd0, 1'b0));
    send_item(make_item(CMD_SOLVE, 4'd0, 4'd0, 1'b0));
    send_item(make_item(CMD_READ, 4'd15, 4'd15, 1'b0));
    send_item(make_item(CMD_SOLVE, 4'd0, 4'd0, 1'b0));
    configure(5'd16, 4'd15, 4'd15, 4'd0, 4'd0);
    send_item(make_item(CMD_SOLVE, 4'd0, 4'd0, 1'b0));
    send_item(make_item(CMD_READ, 4'd7, 4'd8, 1'b0));

    // Random episodes: mostly load a maze, solve it and read it back.
    base    = sent;
    span    = 900 - base;
    squeeze = 1'b1;
    done    = 0;
    while (done < span) begin
      pace = (done < span / 3) ? PACE_SLOW_DRAIN :
             (done < 2 * span / 3) ? PACE_SLOW_FEED : PACE_FULL;
      kind = int'($urandom_range(99));
      pick = int'($urandom_range(99));
      if (squeeze) n = 8;
      else if (pick < 2) n = 0;
      else if (pick < 70) n = int'($urandom_range(6, 1));
      else if (pick < 94) n = int'($urandom_range(12, 7));
      else n = int'($urandom_range(31, 16));
      eff = (n > GRID) ? GRID : n;
      if (eff == 0) begin
        sr = int'($urandom_range(15));
        sc = int'($urandom_range(15));
        gr = int'($urandom_range(15));
        gc = int'($urandom_range(15));
      end else begin
        sr = int'($urandom_range(eff - 1));
        sc = int'($urandom_range(eff - 1));
        gr = int'($urandom_range(eff - 1));
        gc = int'($urandom_range(eff - 1));
        if (int'($urandom_range(99)) < 5) begin
          gr = sr;
          gc = sc;
        end
        // Now and then push one coordinate past the edge of the maze.
        if (eff < GRID && int'($urandom_range(99)) < 10) begin
          case ($urandom_range(3))
            0: sr = int'($urandom_range(15, eff));
            1: sc = int'($urandom_range(15, eff));
            2: gr = int'($urandom_range(15, eff));
            default: gc = int'($urandom_range(15, eff));
          endcase
        end
      end
      configure(5'(n), 4'(sr), 4'(sc), 4'(gr), 4'(gc));

      if (kind < 15 && !squeeze) begin
        // Noise: any command with any field values.
        reps = int'($urandom_range(30, 10));
        repeat (reps) begin
          send_item(make_item(2'($urandom_range(3)), 4'($urandom_range(15)),
                              4'($urandom_range(15)), 1'($urandom_range(1))));
        end
      end else begin
        // In the first episode the receiver holds off while the loads keep coming.
        if (squeeze) hold_requests++;
        for (r = 0; r < eff; r++) begin
          for (c = 0; c < eff; c++) begin
            wall = (r == gr && c == gc) ? (int'($urandom_range(99)) < 10)
                                        : (int'($urandom_range(99)) < 30);
            send_item(make_item(CMD_LOAD, 4'(r), 4'(c), wall));
            if (int'($urandom_range(99)) < 8) begin
              send_item(make_item(($urandom_range(1) != 0) ? CMD_READ : CMD_UNUSED,
                                  4'($urandom_range(15)), 4'($urandom_range(15)),
                                  1'($urandom_range(1))));
            end
          end
        end
        send_item(make_item(CMD_SOLVE, 4'($urandom_range(15)), 4'($urandom_range(15)),
                            1'($urandom_range(1))));
        // Broken sequence: solve again over the marks just left behind.
        if (kind < 25) begin
          send_item(make_item(CMD_SOLVE, 4'd0, 4'd0, 1'b0));
        end
        reps = int'($urandom_range(6, 2));
        repeat (reps) begin
          if (eff > 0 && int'($urandom_range(99)) < 80) begin
            send_item(make_item(CMD_READ, 4'($urandom_range(eff - 1)),
                                4'($urandom_range(eff - 1)), 1'($urandom_range(1))));
          end else begin
            send_item(make_item(CMD_READ, 4'($urandom_range(15)), 4'($urandom_range(15)),
                                1'($urandom_range(1))));
          end
        end
      end
      squeeze = 1'b0;
      done = sent - base;
    end

    // Wait for the last replies, then let the block idle before the summary.
    in_valid <= 1'b0;
    while (maze_watch.awaited_replies.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Covered %0d commands: %0d solves (%0d found, %0d no path, %0d outside), %0d reads.",
             sent, maze_watch.solves, maze_watch.found, maze_watch.no_path,
             maze_watch.outside, maze_watch.reads);
    $display("Maze sizes 0 to 31, both idling patterns, and one long hold-off at the output.");
    if (maze_watch.errors == 0 && maze_watch.awaited_replies.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+rtl
rtl/mdfs_pkg.sv
rtl/mdfs_ram.sv
rtl/mdfs_walk.sv
rtl/maze_depth_first_solver_unit.sv
sim/testbench.sv
